FILE: rtl/core/tmbc_pkg.sv
package tmbc_pkg;

   localparam int COLS_W     = 7;
   localparam int ROWS_W     = 6;
   localparam int CSR_DATA_W = 7;
   localparam int CSR_IDX_W  = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_COLS_IN_USE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_IN_USE = 1'd1;

   localparam logic [COLS_W-1:0] COLS_RESET = 7'd40;
   localparam logic [ROWS_W-1:0] ROWS_RESET = 6'd30;

   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   typedef struct packed {
      logic               func;
      logic [5:0]         tile_col;
      logic [4:0]         tile_row;
      logic               tile_solid;
      logic signed [15:0] rect_left;
      logic signed [15:0] rect_right;
      logic signed [15:0] rect_top;
      logic signed [15:0] rect_bottom;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic [11:0] chip_left;
      logic [11:0] chip_right;
      logic [10:0] chip_top;
      logic [10:0] chip_bottom;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD_RD,
      ST_LOAD_WR,
      ST_PREP,
      ST_SCAN,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic prep;
      logic scan;
      logic step;
   } scan_ctrl_type;

endpackage

FILE: rtl/core/tmbc_ram.sv
module tmbc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

FILE: rtl/core/tmbc_scan_unit.sv
module tmbc_scan_unit #(
   parameter int MAP_COLS  = 64,
   parameter int MAP_ROWS  = 32,
   parameter int TILE_SIZE = 32,
   localparam int RW  = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1,
   localparam int NRW = $clog2(MAP_ROWS + 1)
) (
   input  logic                    clock,
   input  tmbc_pkg::scan_ctrl_type ctrl,
   input  logic signed [15:0]      rect_left,
   input  logic signed [15:0]      rect_right,
   input  logic signed [15:0]      rect_top,
   input  logic signed [15:0]      rect_bottom,
   input  logic [NRW-1:0]          nrows,
   input  logic [MAP_ROWS-1:0]     rd_word,
   output logic                    col_hit,
   output logic [11:0]             chip_left,
   output logic [11:0]             chip_right,
   output logic [10:0]             chip_top,
   output logic [10:0]             chip_bottom
);

   import tmbc_pkg::*;

   localparam int XB = $clog2(MAP_COLS * TILE_SIZE + TILE_SIZE + 1);
   localparam int XW = ((XB > 16) ? XB : 16) + 1;
   localparam int YB = $clog2(MAP_ROWS * TILE_SIZE + TILE_SIZE + 1);
   localparam int YW = ((YB > 16) ? YB : 16) + 1;

   logic [MAP_ROWS-1:0] row_mask_ff, row_mask_in;
   logic [XW-1:0]       col_left_ff, col_left_in;
   logic [RW-1:0]       hit_row_ff, hit_row_in;

   logic signed [XW-1:0] rl_x, rr_x, left_x, right_x;
   logic signed [YW-1:0] rt_y, rb_y;
   logic                 col_ok;
   logic [MAP_ROWS-1:0]  hits;
   logic [RW-1:0]        first_row;
   logic [YW-1:0]        top_px;
   logic [XW-1:0]        right_px;

   assign rl_x    = XW'(rect_left);
   assign rr_x    = XW'(rect_right);
   assign rt_y    = YW'(rect_top);
   assign rb_y    = YW'(rect_bottom);
   assign left_x  = $signed(col_left_ff);
   assign right_px = col_left_ff + XW'(TILE_SIZE);
   assign right_x = $signed(right_px);

   assign col_ok  = (left_x <= rr_x) && (right_x >= rl_x);
   assign hits    = rd_word & row_mask_ff & {MAP_ROWS{col_ok}};
   assign col_hit = |hits;

   always_comb begin
      first_row = '0;
      for (int r = MAP_ROWS - 1; r >= 0; r--) begin
         if (hits[r]) begin
            first_row = RW'(r);
         end
      end
   end

   always_comb begin
      row_mask_in = row_mask_ff;
      if (ctrl.prep) begin
         for (int r = 0; r < MAP_ROWS; r++) begin
            row_mask_in[r] = ($signed(YW'(r * TILE_SIZE)) <= rb_y)
                          && ($signed(YW'(r * TILE_SIZE + TILE_SIZE)) >= rt_y)
                          && (r < int'(nrows));
         end
      end
   end

   always_comb begin
      col_left_in = col_left_ff;
      if (ctrl.prep) begin
         col_left_in = '0;
      end else if (ctrl.step) begin
         col_left_in = right_px;
      end
   end

   always_comb begin
      hit_row_in = hit_row_ff;
      if (ctrl.scan && col_hit) begin
         hit_row_in = first_row;
      end
   end

   always_ff @(posedge clock) begin
      row_mask_ff <= row_mask_in;
      col_left_ff <= col_left_in;
      hit_row_ff  <= hit_row_in;
   end

   assign top_px      = YW'(hit_row_ff) * YW'(TILE_SIZE);
   assign chip_left   = 12'(col_left_ff);
   assign chip_right  = 12'(right_px);
   assign chip_top    = 11'(top_px);
   assign chip_bottom = 11'(top_px + YW'(TILE_SIZE));

endmodule

FILE: rtl/core/tile_map_box_collision_unit.sv
// Load: accepted, then a read and a write of the column word (no write for a tile
// outside the map); the next beat is accepted once the unit is back in idle.
// Query: a prepare step, then one tile column per cycle through the shared compare
// unit over up to min(cols_in_use, MAP_COLS) columns, stopping at the first hit, then
// a result step registers the result. Reset: cols_in_use 40, rows_in_use 30; the tile
// store is swept to zero, with req_stall high, before the first beat is accepted.
module tile_map_box_collision_unit #(
   parameter int MAP_COLS  = 64,
   parameter int MAP_ROWS  = 32,
   parameter int TILE_SIZE = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  tmbc_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output tmbc_pkg::rsp_type                   rsp_data,
   input  logic                                csr_wr_en,
   input  logic [tmbc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tmbc_pkg::CSR_DATA_W-1:0]     csr_wr_data
);

   import tmbc_pkg::*;

   localparam int CW  = (MAP_COLS > 1) ? $clog2(MAP_COLS) : 1;
   localparam int RW  = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;
   localparam int NW  = $clog2(MAP_COLS + 1);
   localparam int NRW = $clog2(MAP_ROWS + 1);

   state_type   state_ff, state_in;
   req_type     req_ff, req_in;
   rsp_type     rsp_ff, rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0] col_ff, col_in;
   logic        found_ff, found_in;
   logic [COLS_W-1:0] cols_ff, cols_in;
   logic [ROWS_W-1:0] rows_ff, rows_in;

   logic [NW-1:0]  ncols;
   logic [NRW-1:0] nrows;
   logic           req_accept;
   logic           last_col;
   logic           load_in_map;
   logic [CW-1:0]  load_col;
   logic [RW-1:0]  load_row;

   logic                ram_we;
   logic [CW-1:0]       ram_wr_addr;
   logic [MAP_ROWS-1:0] ram_wr_data;
   logic [CW-1:0]       ram_rd_addr;
   logic [MAP_ROWS-1:0] ram_rd_data;

   scan_ctrl_type ctrl;
   logic          col_hit;
   logic [11:0]   s_left, s_right;
   logic [10:0]   s_top, s_bottom;

   assign ncols = (int'(cols_ff) > MAP_COLS) ? NW'(MAP_COLS) : NW'(cols_ff);
   assign nrows = (int'(rows_ff) > MAP_ROWS) ? NRW'(MAP_ROWS) : NRW'(rows_ff);

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign last_col   = ((NW'(col_ff) + NW'(1)) == ncols);

   assign load_in_map = (int'(req_ff.tile_col) < MAP_COLS) && (int'(req_ff.tile_row) < MAP_ROWS);
   assign load_col    = CW'(req_ff.tile_col);
   assign load_row    = RW'(req_ff.tile_row);

   tmbc_ram #(
      .WIDTH (MAP_ROWS),
      .DEPTH (MAP_COLS)
   ) u_tile_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   tmbc_scan_unit #(
      .MAP_COLS  (MAP_COLS),
      .MAP_ROWS  (MAP_ROWS),
      .TILE_SIZE (TILE_SIZE)
   ) u_scan (
      .clock       (clock),
      .ctrl        (ctrl),
      .rect_left   (req_ff.rect_left),
      .rect_right  (req_ff.rect_right),
      .rect_top    (req_ff.rect_top),
      .rect_bottom (req_ff.rect_bottom),
      .nrows       (nrows),
      .rd_word     (ram_rd_data),
      .col_hit     (col_hit),
      .chip_left   (s_left),
      .chip_right  (s_right),
      .chip_top    (s_top),
      .chip_bottom (s_bottom)
   );

   always_comb begin
      cols_in = cols_ff;
      rows_in = rows_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_COLS_IN_USE: cols_in = csr_wr_data[COLS_W-1:0];
            CSR_ROWS_IN_USE: rows_in = csr_wr_data[ROWS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      col_in       = col_ff;
      found_in     = found_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ctrl         = '0;
      ram_we       = 1'b0;
      ram_wr_addr  = col_ff;
      ram_wr_data  = '0;
      ram_rd_addr  = col_ff;

      case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
            col_in = CW'(col_ff + CW'(1));
            if (col_ff == CW'(MAP_COLS - 1)) begin
               col_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               req_in   = req_data;
               state_in = (req_data.func == FUNC_QUERY) ? ST_PREP : ST_LOAD_RD;
            end
         end
         ST_LOAD_RD: begin
            ram_rd_addr = load_col;
            state_in    = load_in_map ? ST_LOAD_WR : ST_IDLE;
         end
         ST_LOAD_WR: begin
            ram_we               = 1'b1;
            ram_wr_addr          = load_col;
            ram_wr_data          = ram_rd_data;
            ram_wr_data[load_row] = req_ff.tile_solid;
            state_in             = ST_IDLE;
         end
         ST_PREP: begin
            ctrl.prep   = 1'b1;
            ram_rd_addr = '0;
            col_in      = '0;
            found_in    = 1'b0;
            state_in    = (ncols == '0) ? ST_RESULT : ST_SCAN;
         end
         ST_SCAN: begin
            ctrl.scan   = 1'b1;
            ram_rd_addr = CW'(col_ff + CW'(1));
            if (col_hit) begin
               found_in = 1'b1;
               state_in = ST_RESULT;
            end else if (last_col) begin
               state_in = ST_RESULT;
            end else begin
               ctrl.step = 1'b1;
               col_in    = CW'(col_ff + CW'(1));
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               rsp_in.hit   = found_ff;
               if (found_ff) begin
                  rsp_in.chip_left   = s_left;
                  rsp_in.chip_right  = s_right;
                  rsp_in.chip_top    = s_top;
                  rsp_in.chip_bottom = s_bottom;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         col_ff       <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cols_ff      <= COLS_RESET;
         rows_ff      <= ROWS_RESET;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
         cols_ff      <= cols_in;
         rows_ff      <= rows_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_clear_writes_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> (ram_we && (ram_wr_data == '0)))
      else $error("clear sweep must write zero words");

   a_result_from_seq: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_RESULT))
      else $error("result beat raised outside the result step");

   a_miss_zero_bounds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.hit) |-> ((rsp_ff.chip_left == '0) && (rsp_ff.chip_right == '0)
         && (rsp_ff.chip_top == '0) && (rsp_ff.chip_bottom == '0)))
      else $error("miss carries non-zero bounds");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (NW'(col_ff) < ncols))
      else $error("scan column beyond columns in use");

endmodule

FILE: dv/tb_tile_map_box_collision_unit.sv
`timescale 1ns / 100ps

module tb_tile_map_box_collision_unit;
   import tmbc_pkg::*;

   localparam int MAP_COLS    = 64;
   localparam int MAP_ROWS    = 32;
   localparam int TILE_SIZE   = 32;
   localparam int TAIL_CYCLES = MAP_COLS + 16;
   localparam int LONG_HOLD   = 400;
   localparam int SPOT_LIMIT  = 48;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   req_type               req_data    = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_wr_en   = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index   = CSR_COLS_IN_USE;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;

   bit                tile_mirror [MAP_COLS][MAP_ROWS];
   logic [COLS_W-1:0] cols_cfg = COLS_RESET;
   logic [ROWS_W-1:0] rows_cfg = ROWS_RESET;
   req_type           pending_beats[$];
   rsp_type           expected_chips[$];
   logic [10:0]       solid_spots[$];

   int send_idle_pct  = 0;
   int stall_pct      = 0;
   int long_hold_reqs = 0;
   int long_hold_done = 0;
   int long_hold_left = 0;
   int errors         = 0;
   int loads_seen     = 0;
   int queries_seen   = 0;
   int results_seen   = 0;
   int hits_seen      = 0;
   bit req_beat       = 1'b0;
   bit rsp_beat       = 1'b0;

   tile_map_box_collision_unit #(
      .MAP_COLS  (MAP_COLS),
      .MAP_ROWS  (MAP_ROWS),
      .TILE_SIZE (TILE_SIZE)
   ) dut (.*);

   always #2 clock = ~clock;

   function automatic rsp_type predict_collision(req_type q);
      rsp_type chip;
      int      ncols, nrows, rl, rr, rt, rb, left, top;
      chip  = '0;
      ncols = (cols_cfg > MAP_COLS) ? MAP_COLS : int'(cols_cfg);
      nrows = (rows_cfg > MAP_ROWS) ? MAP_ROWS : int'(rows_cfg);
      rl    = $signed(q.rect_left);
      rr    = $signed(q.rect_right);
      rt    = $signed(q.rect_top);
      rb    = $signed(q.rect_bottom);
      for (int c = 0; c < ncols; c++) begin
         for (int r = 0; r < nrows; r++) begin
            left = c * TILE_SIZE;
            top  = r * TILE_SIZE;
            if (tile_mirror[c][r] && !(left > rr || top > rb ||
                left + TILE_SIZE < rl || top + TILE_SIZE < rt)) begin
               chip.hit         = 1'b1;
               chip.chip_left   = left[11:0];
               chip.chip_right  = 12'(left + TILE_SIZE);
               chip.chip_top    = top[10:0];
               chip.chip_bottom = 11'(top + TILE_SIZE);
               return chip;
            end
         end
      end
      return chip;
   endfunction

   task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
      errors++;
      $display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
   endtask

   task automatic check_chip(rsp_type got);
      rsp_type want;
      results_seen++;
      if (expected_chips.size() == 0) begin
         report_mismatch("result with nothing outstanding", 48'(got), '0);
         return;
      end
      want = expected_chips.pop_front();
      if (want.hit)
         hits_seen++;
      if (got.hit !== want.hit)
         report_mismatch("hit", 48'(got.hit), 48'(want.hit));
      if (got.chip_left !== want.chip_left)
         report_mismatch("chip_left", 48'(got.chip_left), 48'(want.chip_left));
      if (got.chip_right !== want.chip_right)
         report_mismatch("chip_right", 48'(got.chip_right), 48'(want.chip_right));
      if (got.chip_top !== want.chip_top)
         report_mismatch("chip_top", 48'(got.chip_top), 48'(want.chip_top));
      if (got.chip_bottom !== want.chip_bottom)
         report_mismatch("chip_bottom", 48'(got.chip_bottom), 48'(want.chip_bottom));
   endtask

   // monitor: check the result beat first, it belongs to an older query
   always @(posedge clock) begin
      req_beat = !reset && req_valid && !req_stall;
      rsp_beat = !reset && rsp_valid && !rsp_stall;
      if (rsp_beat)
         check_chip(rsp_data);
      if (req_beat) begin
         if (req_data.func == FUNC_QUERY) begin
            expected_chips.push_back(predict_collision(req_data));
            queries_seen++;
         end else begin
            tile_mirror[req_data.tile_col][req_data.tile_row] = req_data.tile_solid;
            loads_seen++;
         end
      end
   end

   // driver: hold the beat until taken, then advance or idle
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_beat) begin
         if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_data  <= pending_beats.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (long_hold_done != long_hold_reqs) begin
         long_hold_done++;
         long_hold_left = LONG_HOLD;
      end
      if (long_hold_left > 0) begin
         long_hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic settle();
      @(posedge clock);
      #1;
   endtask

   task automatic wait_quiet();
      while (pending_beats.size() != 0 || req_valid || expected_chips.size() != 0)
         settle();
      repeat (TAIL_CYCLES) settle();
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_COLS_IN_USE)
         cols_cfg = value[COLS_W-1:0];
      else if (idx == CSR_ROWS_IN_USE)
         rows_cfg = value[ROWS_W-1:0];
      settle();
   endtask

   task automatic set_map_size(int cols, int rows);
      write_csr(CSR_COLS_IN_USE, cols[CSR_DATA_W-1:0]);
      write_csr(CSR_ROWS_IN_USE, rows[CSR_DATA_W-1:0]);
   endtask

   function automatic req_type noise_beat();
      logic [95:0] bits;
      bits = {$urandom, $urandom, $urandom};
      return bits[$bits(req_type)-1:0];
   endfunction

   task automatic queue_load(int col, int row, bit solid);
      req_type b;
      b            = noise_beat();
      b.func       = FUNC_LOAD;
      b.tile_col   = col[5:0];
      b.tile_row   = row[4:0];
      b.tile_solid = solid;
      pending_beats.push_back(b);
      if (solid) begin
         solid_spots.push_back({col[5:0], row[4:0]});
         if (solid_spots.size() > SPOT_LIMIT)
            void'(solid_spots.pop_front());
      end
   endtask

   task automatic queue_query(int l, int r, int t, int b);
      req_type q;
      q             = noise_beat();
      q.func        = FUNC_QUERY;
      q.rect_left   = l[15:0];
      q.rect_right  = r[15:0];
      q.rect_top    = t[15:0];
      q.rect_bottom = b[15:0];
      pending_beats.push_back(q);
   endtask

   task automatic queue_random_load(int solid_pct);
      int col, row, col_lim, row_lim;
      col_lim = (cols_cfg == 0 || cols_cfg > MAP_COLS) ? MAP_COLS : int'(cols_cfg);
      row_lim = (rows_cfg == 0 || rows_cfg > MAP_ROWS) ? MAP_ROWS : int'(rows_cfg);
      if ($urandom_range(99) < 75) begin
         col = $urandom_range(0, col_lim - 1);
         row = $urandom_range(0, row_lim - 1);
      end else begin
         col = $urandom_range(0, MAP_COLS - 1);
         row = $urandom_range(0, MAP_ROWS - 1);
      end
      queue_load(col, row, $urandom_range(99) < solid_pct);
   endtask

   task automatic queue_random_query();
      int kind, spot, px, py, w, h, l, r, t, b, swap;
      kind = $urandom_range(99);
      if (kind < 15) begin
         l = $urandom;
         r = $urandom;
         t = $urandom;
         b = $urandom;
      end else if (kind < 35) begin
         // rectangles with edges on or one pixel off the tile grid
         px = $urandom_range(0, MAP_COLS) * TILE_SIZE;
         py = $urandom_range(0, MAP_ROWS) * TILE_SIZE;
         l  = px - 1 + $urandom_range(0, 2);
         r  = l + $urandom_range(0, 2) * TILE_SIZE - 1 + $urandom_range(0, 2);
         t  = py - 1 + $urandom_range(0, 2);
         b  = t + $urandom_range(0, 2) * TILE_SIZE - 1 + $urandom_range(0, 2);
      end else begin
         if (kind < 75 && solid_spots.size() != 0) begin
            spot = $urandom_range(0, solid_spots.size() - 1);
            px   = int'(solid_spots[spot][10:5]) * TILE_SIZE + $urandom_range(0, 40) - 4;
            py   = int'(solid_spots[spot][4:0]) * TILE_SIZE + $urandom_range(0, 40) - 4;
         end else begin
            px = $urandom_range(0, 2200) - 100;
            py = $urandom_range(0, 1150) - 60;
         end
         w = ($urandom_range(99) < 15) ? $urandom_range(0, 1200) : $urandom_range(0, 48);
         h = ($urandom_range(99) < 15) ? $urandom_range(0, 600) : $urandom_range(0, 48);
         l = px - $urandom_range(0, w);
         r = l + w;
         t = py - $urandom_range(0, h);
         b = t + h;
         if ($urandom_range(99) < 6) begin
            swap = l;
            l    = r;
            r    = swap;
         end
         if ($urandom_range(99) < 6) begin
            swap = t;
            t    = b;
            b    = swap;
         end
      end
      queue_query(l, r, t, b);
   endtask

   task automatic queue_burst(int count, int solid_pct, int query_pct);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < query_pct)
            queue_random_query();
         else
            queue_random_load(solid_pct);
      end
   endtask

   initial begin
      int send_mix[4];
      int stall_mix[4];
      int solid_mix[3];
      send_mix  = '{0, 68, 0, 29};
      stall_mix = '{0, 0, 68, 29};
      solid_mix = '{15, 50, 85};

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      settle();

      // empty map, edges, touching, inverted, column-major order
      queue_query(-32768, 32767, -32768, 32767);
      queue_load(0, 0, 1'b1);
      queue_query(0, 0, 0, 0);
      queue_query(32, 40, 10, 10);
      queue_query(33, 40, 10, 10);
      queue_query(-5, -1, 0, 0);
      queue_query(20, 10, 20, 10);
      queue_query(100, 0, 0, 0);
      queue_load(63, 31, 1'b1);
      queue_query(2016, 2048, 992, 1024);
      queue_load(2, 5, 1'b1);
      queue_load(3, 1, 1'b1);
      queue_query(64, 200, 0, 400);
      queue_load(0, 0, 1'b0);
      queue_query(-32768, -32768, -32768, -32768);
      queue_query(32767, 32767, 32767, 32767);
      queue_query(-32768, 32767, -32768, 32767);
      wait_quiet();
      set_map_size(MAP_COLS, MAP_ROWS);
      queue_query(2016, 2048, 992, 1024);
      queue_query(2048, 2048, 1024, 1024);
      wait_quiet();
      set_map_size(0, MAP_ROWS);
      queue_query(-32768, 32767, -32768, 32767);
      wait_quiet();
      set_map_size(MAP_COLS, 0);
      queue_query(-32768, 32767, -32768, 32767);
      wait_quiet();
      set_map_size(127, 127);
      queue_query(-32768, 32767, -32768, 32767);

      for (int ph = 0; ph < 12; ph++) begin
         wait_quiet();
         case (ph)
            0: set_map_size(MAP_COLS, MAP_ROWS);
            1: set_map_size(127, 127);
            2: set_map_size(COLS_RESET, ROWS_RESET);
            3: set_map_size(1, 1);
            4: set_map_size(0, MAP_ROWS);
            5: set_map_size(MAP_COLS, 0);
            default: set_map_size($urandom_range(1, 72), $urandom_range(1, 40));
         endcase
         send_idle_pct = send_mix[ph % 4];
         stall_pct     = stall_mix[ph % 4];
         queue_burst((ph == 4 || ph == 5) ? 30 : 95, solid_mix[ph % 3], 50);
      end

      // long receiver hold-off with the sender flat out
      wait_quiet();
      set_map_size(MAP_COLS, MAP_ROWS);
      send_idle_pct = 0;
      stall_pct     = 0;
      long_hold_reqs++;
      queue_burst(60, 50, 80);

      wait_quiet();
      $display("%0d loads and %0d queries sent; %0d results checked, %0d with a hit",
               loads_seen, queries_seen, results_seen, hits_seen);
      $display("covered map sizes from none to saturated, grid-edge rectangles, "
               , "random gaps and stalls, and a long hold-off");
      if (errors == 0)
         $display("** tile_map_box_collision_unit: PASSED **");
      else
         $display("** tile_map_box_collision_unit: FAILED **");
      $finish;
   end

   initial begin
      #4ms;
      $display("timeout with %0d results outstanding", expected_chips.size());
      $display("** tile_map_box_collision_unit: FAILED **");
      $finish;
   end

endmodule
